@@ rtl/isots_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isots_pkg: shared types and helpers of the ISO 8601 timestamp converter
// Character codes, parse phases, the parsed-field record passed from the
// character front end to the date arithmetic, and small lookup functions.
// ----------------------------------------------------------------------------
package isots_pkg;

  localparam int unsigned EPOCH_W = 39;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_UP_T  = 8'd84;
  localparam logic [7:0] CH_UP_Z  = 8'd90;
  localparam logic [7:0] CH_LO_T  = 8'd116;
  localparam logic [7:0] CH_LO_Z  = 8'd122;

  // Zone sign codes
  localparam logic [1:0] ZS_NONE  = 2'd0;
  localparam logic [1:0] ZS_PLUS  = 2'd1;
  localparam logic [1:0] ZS_MINUS = 2'd2;

  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_BODY   = 6'b000010,
    PH_AFTSEC = 6'b000100,
    PH_FRAC   = 6'b001000,
    PH_ZONE   = 6'b010000,
    PH_TAIL   = 6'b100000
  } phase_t;

  typedef enum logic [5:0] {
    BK_IDLE = 6'b000001,
    BK_NORM = 6'b000010,
    BK_DIV  = 6'b000100,
    BK_DAYS = 6'b001000,
    BK_SECS = 6'b010000,
    BK_DONE = 6'b100000
  } bk_state_t;

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [1:0]  zsign;
    logic [6:0]  zhour;
    logic [6:0]  zminute;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } q_wr_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Day of year of the first of a March-based month (0 is March)
  function automatic logic [8:0] doy_of(input logic [3:0] mp);
    logic [8:0] d;
    unique case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/isots_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isots_front: character parser
// Checks the timestamp shape one byte per accepted cycle, gathers the numeric
// fields and emits one record per string on its last character.
// ----------------------------------------------------------------------------
module isots_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           char_code,
  input  logic                 is_last,
  input  logic                 accept,
  output isots_pkg::q_wr_t     q_wr
);

  isots_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  second_r, second_nxt;
  logic [1:0]  zsign_r, zsign_nxt;
  logic [6:0]  zhour_r, zhour_nxt;
  logic [6:0]  zminute_r, zminute_nxt;
  logic        failed_r, failed_nxt;

  logic       ws, dig, do_body, do_after;
  logic [4:0] p;
  logic [3:0] d;

  assign ws  = isots_pkg::is_ws(char_code);
  assign dig = isots_pkg::is_digit(char_code);
  assign d   = 4'(char_code - isots_pkg::CH_ZERO);

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    zsign_nxt   = zsign_r;
    zhour_nxt   = zhour_r;
    zminute_nxt = zminute_r;
    failed_nxt  = failed_r;
    do_body     = 1'b0;
    do_after    = 1'b0;
    p           = pos_r;

    if (!failed_r) begin
      unique case (phase_r)
        isots_pkg::PH_LEAD: begin
          if (!ws) begin
            phase_nxt = isots_pkg::PH_BODY;
            p         = 5'd0;
            do_body   = 1'b1;
          end
        end
        isots_pkg::PH_BODY: do_body = 1'b1;
        isots_pkg::PH_AFTSEC: begin
          if (char_code == isots_pkg::CH_DOT) phase_nxt = isots_pkg::PH_FRAC;
          else do_after = 1'b1;
        end
        isots_pkg::PH_FRAC: begin
          if (!dig) do_after = 1'b1;
        end
        isots_pkg::PH_ZONE: begin
          if (pos_r == 5'd2) begin
            if (char_code != isots_pkg::CH_COLON) failed_nxt = 1'b1;
          end else if (pos_r <= 5'd1) begin
            if (dig) zhour_nxt = 7'(zhour_r * 7'd10 + 7'(d));
            else failed_nxt = 1'b1;
          end else begin
            if (dig) zminute_nxt = 7'(zminute_r * 7'd10 + 7'(d));
            else failed_nxt = 1'b1;
          end
          if (pos_r >= 5'd4) phase_nxt = isots_pkg::PH_TAIL;
          else pos_nxt = 5'(pos_r + 5'd1);
        end
        isots_pkg::PH_TAIL: begin
          if (!ws) failed_nxt = 1'b1;
        end
        default: failed_nxt = 1'b1;
      endcase
    end

    if (do_body) begin
      priority if (p <= 5'd3) begin
        if (dig) year_nxt = 14'(year_r * 14'd10 + 14'(d));
        else failed_nxt = 1'b1;
      end else if (p == 5'd4 || p == 5'd7) begin
        if (char_code != isots_pkg::CH_MINUS) failed_nxt = 1'b1;
      end else if (p == 5'd5 || p == 5'd6) begin
        if (dig) month_nxt = 7'(month_r * 7'd10 + 7'(d));
        else failed_nxt = 1'b1;
      end else if (p == 5'd8 || p == 5'd9) begin
        if (dig) day_nxt = 7'(day_r * 7'd10 + 7'(d));
        else failed_nxt = 1'b1;
      end else if (p == 5'd10) begin
        if (char_code != isots_pkg::CH_UP_T && char_code != isots_pkg::CH_LO_T &&
            char_code != isots_pkg::CH_SPACE) failed_nxt = 1'b1;
      end else if (p == 5'd11 || p == 5'd12) begin
        if (dig) hour_nxt = 7'(hour_r * 7'd10 + 7'(d));
        else failed_nxt = 1'b1;
      end else if (p == 5'd13 || p == 5'd16) begin
        if (char_code != isots_pkg::CH_COLON) failed_nxt = 1'b1;
      end else if (p == 5'd14 || p == 5'd15) begin
        if (dig) minute_nxt = 7'(minute_r * 7'd10 + 7'(d));
        else failed_nxt = 1'b1;
      end else begin
        if (dig) second_nxt = 7'(second_r * 7'd10 + 7'(d));
        else failed_nxt = 1'b1;
      end
      if (p >= 5'd18) phase_nxt = isots_pkg::PH_AFTSEC;
      else pos_nxt = 5'(p + 5'd1);
    end

    // Character after the seconds or the fraction digits
    if (do_after) begin
      if (char_code == isots_pkg::CH_UP_Z || char_code == isots_pkg::CH_LO_Z || ws) begin
        phase_nxt = isots_pkg::PH_TAIL;
      end else if (char_code == isots_pkg::CH_PLUS || char_code == isots_pkg::CH_MINUS) begin
        zsign_nxt = (char_code == isots_pkg::CH_PLUS) ? isots_pkg::ZS_PLUS
                                                      : isots_pkg::ZS_MINUS;
        phase_nxt = isots_pkg::PH_ZONE;
        pos_nxt   = 5'd0;
      end else begin
        failed_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    q_wr.push        = accept && is_last;
    q_wr.rec.ok      = !failed_nxt && (phase_nxt == isots_pkg::PH_AFTSEC ||
                                       phase_nxt == isots_pkg::PH_FRAC ||
                                       phase_nxt == isots_pkg::PH_TAIL);
    q_wr.rec.year    = year_nxt;
    q_wr.rec.month   = month_nxt;
    q_wr.rec.day     = day_nxt;
    q_wr.rec.hour    = hour_nxt;
    q_wr.rec.minute  = minute_nxt;
    q_wr.rec.second  = second_nxt;
    q_wr.rec.zsign   = zsign_nxt;
    q_wr.rec.zhour   = zhour_nxt;
    q_wr.rec.zminute = zminute_nxt;
  end

  // Restart from the reset values after each last character
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && is_last)) begin
      phase_r   <= isots_pkg::PH_LEAD;
      pos_r     <= '0;
      year_r    <= '0;
      month_r   <= '0;
      day_r     <= '0;
      hour_r    <= '0;
      minute_r  <= '0;
      second_r  <= '0;
      zsign_r   <= isots_pkg::ZS_NONE;
      zhour_r   <= '0;
      zminute_r <= '0;
      failed_r  <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      year_r    <= year_nxt;
      month_r   <= month_nxt;
      day_r     <= day_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      second_r  <= second_nxt;
      zsign_r   <= zsign_nxt;
      zhour_r   <= zhour_nxt;
      zminute_r <= zminute_nxt;
      failed_r  <= failed_nxt;
    end
  end

endmodule

@@ rtl/isots_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isots_fifo: record queue
// Short queue of parsed records between the parser and the date arithmetic.
// ----------------------------------------------------------------------------
module isots_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  isots_pkg::q_wr_t    wr,
  input  logic                rd,
  output isots_pkg::rec_t     rd_rec,
  output logic                full,
  output logic                empty
);

  isots_pkg::rec_t mem_r [isots_pkg::Q_DEPTH];
  logic [isots_pkg::Q_AW-1:0] wptr_r, rptr_r;
  logic [isots_pkg::Q_AW:0]   cnt_r;
  logic                       do_wr, do_rd;

  assign full   = (cnt_r == (isots_pkg::Q_AW+1)'(isots_pkg::Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr.push && !full;
  assign do_rd  = rd && !empty;
  assign rd_rec = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr.rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= isots_pkg::Q_AW'(wptr_r + 1'b1);
      if (do_rd) rptr_r <= isots_pkg::Q_AW'(rptr_r + 1'b1);
      unique case ({do_wr, do_rd})
        2'b10:   cnt_r <= (isots_pkg::Q_AW+1)'(cnt_r + 1'b1);
        2'b01:   cnt_r <= (isots_pkg::Q_AW+1)'(cnt_r - 1'b1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/isots_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isots_back: date arithmetic
// Turns one parsed record into Unix seconds over a short sequence of
// registered steps and holds the result in the output register.
// ----------------------------------------------------------------------------
module isots_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  isots_pkg::rec_t                   q_rec,
  input  logic                              q_empty,
  output logic                              q_rd,
  input  logic                              out_pop,
  output logic                              out_empty,
  output logic                              out_ok,
  output logic signed [isots_pkg::EPOCH_W-1:0] out_epoch_seconds
);

  isots_pkg::bk_state_t state_r, state_nxt;
  isots_pkg::rec_t rec_r;

  logic [13:0]        yy_r;      // year + 400, March-based
  logic [3:0]         mp_r;      // month index, 0 is March
  logic [18:0]        hms_r;
  logic [18:0]        off_r;
  logic [6:0]         q100_r;
  logic [21:0]        y365_r;
  logic signed [23:0] days_r;
  logic signed [40:0] t_r;

  logic                              ok_r;
  logic signed [isots_pkg::EPOCH_W-1:0] epoch_r;
  logic                              out_valid_r;

  logic        m_dec;
  logic [6:0]  m0;
  logic [3:0]  q12, r12;
  logic [12:0] m0_x43;
  logic [15:0] ysum;
  logic [26:0] yy_x;
  logic signed [40:0] t_adj;
  logic        t_is_m1, res_ok, slot_free;

  assign q_rd      = (state_r == isots_pkg::BK_IDLE) && !q_empty;
  assign slot_free = !out_valid_r || out_pop;

  // Month carry: month 0 borrows a year, months past 12 roll into years
  always_comb begin
    m_dec  = (rec_r.month == 7'd0);
    m0     = m_dec ? 7'd11 : 7'(rec_r.month - 7'd1);
    m0_x43 = 13'(m0) * 13'd43;
    q12    = 4'(m0_x43 >> 9);
    r12    = 4'(m0 - 7'(q12) * 7'd12);
    ysum   = 16'(rec_r.year) + 16'(q12) + 16'd400 - 16'(m_dec) - 16'(r12 < 4'd2);
  end

  assign yy_x = 27'(yy_r) * 27'd5243;

  always_comb begin
    t_is_m1 = (t_r == -41'sd1);
    res_ok  = rec_r.ok && !t_is_m1;
    unique case (rec_r.zsign)
      isots_pkg::ZS_PLUS:  t_adj = t_r - 41'(off_r);
      isots_pkg::ZS_MINUS: t_adj = t_r + 41'(off_r);
      default:             t_adj = t_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isots_pkg::BK_IDLE: if (!q_empty) state_nxt = isots_pkg::BK_NORM;
      isots_pkg::BK_NORM: state_nxt = isots_pkg::BK_DIV;
      isots_pkg::BK_DIV:  state_nxt = isots_pkg::BK_DAYS;
      isots_pkg::BK_DAYS: state_nxt = isots_pkg::BK_SECS;
      isots_pkg::BK_SECS: state_nxt = isots_pkg::BK_DONE;
      isots_pkg::BK_DONE: if (slot_free) state_nxt = isots_pkg::BK_IDLE;
      default:            state_nxt = isots_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= isots_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_rd) rec_r <= q_rec;
    if (state_r == isots_pkg::BK_NORM) begin
      yy_r  <= 14'(ysum);
      mp_r  <= (r12 >= 4'd2) ? 4'(r12 - 4'd2) : 4'(r12 + 4'd10);
      hms_r <= 19'(rec_r.hour) * 19'd3600 + 19'(rec_r.minute) * 19'd60
               + 19'(rec_r.second);
      off_r <= 19'(rec_r.zhour) * 19'd3600 + 19'(rec_r.zminute) * 19'd60;
    end
    if (state_r == isots_pkg::BK_DIV) begin
      q100_r <= 7'(yy_x >> 19);
      y365_r <= 22'(yy_r) * 22'd365;
    end
    // Days since 1970-01-01: shifted years, their leap days, day of year, day
    if (state_r == isots_pkg::BK_DAYS) begin
      days_r <= $signed(24'(y365_r) + 24'(yy_r >> 2) - 24'(q100_r) + 24'(q100_r >> 2)
                        + 24'(isots_pkg::doy_of(mp_r)) + 24'(rec_r.day) - 24'd865566);
    end
    if (state_r == isots_pkg::BK_SECS) begin
      t_r <= 41'(days_r) * 41'sd86400 + $signed(41'(hms_r));
    end
    if (state_r == isots_pkg::BK_DONE && slot_free) begin
      ok_r    <= res_ok;
      epoch_r <= res_ok ? isots_pkg::EPOCH_W'(t_adj) : '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == isots_pkg::BK_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_ok            = ok_r;
  assign out_epoch_seconds = epoch_r;

endmodule

@@ rtl/iso8601_timestamp_to_epoch_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_core: ISO 8601 text to Unix seconds
// Usage:
//   Input queue: drive one character on in_char_code with in_push; set
//   in_is_last on the final character. A byte is taken at a clock edge with
//   in_push high and in_full low; one per cycle while in_full stays low.
//   Result queue: while out_empty is low, out_ok and out_epoch_seconds hold
//   the oldest result; raise out_pop to take it. One result per string;
//   on any parse error out_ok is 0 and out_epoch_seconds is -1.
//   The last character's record passes the record queue, then the date
//   arithmetic sequencer steps IDLE, NORM, DIV, DAYS, SECS and DONE before
//   the result is registered. The six-step sequencer takes a new record only
//   once it is through with the last; a two-entry record queue between parser
//   and sequencer absorbs short strings, and in_full rises when it fills.
//   When the receiver does not pop, the sequencer holds its finished value,
//   the record queue fills and in_full then stalls the input.
//   Reset (rst_n low, synchronous) empties both queues and restarts parsing
//   at the leading-whitespace phase; no clearing pass is needed.
// ----------------------------------------------------------------------------
module iso8601_timestamp_to_epoch_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [7:0]                           in_char_code,
  input  logic                                 in_is_last,
  input  logic                                 in_push,
  output logic                                 in_full,
  output logic                                 out_ok,
  output logic signed [isots_pkg::EPOCH_W-1:0] out_epoch_seconds,
  output logic                                 out_empty,
  input  logic                                 out_pop
);

  isots_pkg::q_wr_t q_wr;
  isots_pkg::rec_t  q_rec;
  logic             q_rd, q_empty, accept;

  assign accept = in_push && !in_full;

  isots_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_code (in_char_code),
    .is_last   (in_is_last),
    .accept    (accept),
    .q_wr      (q_wr)
  );

  isots_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .rd     (q_rd),
    .rd_rec (q_rec),
    .full   (in_full),
    .empty  (q_empty)
  );

  isots_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rec             (q_rec),
    .q_empty           (q_empty),
    .q_rd              (q_rd),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_ok            (out_ok),
    .out_epoch_seconds (out_epoch_seconds)
  );

endmodule
